### rtl/core/bpg_pkg.sv
// Package for the battery percent gauge: table constants, report kind codes,
// the shared lookup functions and the control struct passed to the filter.
// Depends on nothing.
`default_nettype none

package bpg_pkg;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned PctW    = 7;
  localparam int unsigned AdcLen  = 21;
  localparam int unsigned LinLen  = 13;

  localparam logic [LevelW-1:0] HELD_NONE     = 8'hFF;
  localparam logic [LevelW-1:0] FULL_HOLD     = 8'd90;
  localparam logic [LevelW-1:0] OFFSET_RESET  = 8'd26;

  // Report kind codes; the remaining codes read the ADC table at level zero.
  localparam logic [1:0] KIND_PERCENT = 2'd0;
  localparam logic [1:0] KIND_ADC     = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  localparam logic [LevelW-1:0] ADC_KEY [AdcLen] = '{
    8'd30, 8'd37, 8'd42, 8'd49, 8'd54, 8'd59, 8'd63, 8'd68, 8'd72, 8'd76, 8'd79,
    8'd82, 8'd84, 8'd86, 8'd90, 8'd95, 8'd100, 8'd105, 8'd120, 8'd150, 8'd255
  };
  localparam logic [LevelW-1:0] ADC_PCT [AdcLen] = '{
    8'd100, 8'd95, 8'd90, 8'd85, 8'd80, 8'd75, 8'd70, 8'd65, 8'd60, 8'd55, 8'd50,
    8'd45, 8'd40, 8'd35, 8'd30, 8'd25, 8'd20, 8'd15, 8'd10, 8'd5, 8'd0
  };
  localparam logic [LevelW-1:0] LIN_KEY [LinLen] = '{
    8'd3, 8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90,
    8'd100, 8'd0
  };
  localparam logic [LevelW-1:0] LIN_PCT [LinLen] = '{
    8'd3, 8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90,
    8'd100, 8'd0
  };

  typedef struct packed {
    logic update;
    logic bat;
    logic dc;
    logic full;
  } filt_ctrl_t;

  // First entry whose key is at least the level; the last entry is the
  // terminator and wins only when no earlier key matches.
  function automatic logic [LevelW-1:0] adc_pick(input logic [LevelW-1:0] lvl);
    logic [LevelW-1:0] res;
    res = ADC_PCT[AdcLen-1];
    for (int i = AdcLen - 2; i >= 0; i--) begin
      if (ADC_KEY[i] >= lvl) res = ADC_PCT[i];
    end
    return res;
  endfunction

  function automatic logic [LevelW-1:0] lin_pick(input logic [LevelW-1:0] lvl);
    logic [LevelW-1:0] res;
    res = LIN_PCT[LinLen-1];
    for (int i = LinLen - 2; i >= 0; i--) begin
      if (LIN_KEY[i] >= lvl) res = LIN_PCT[i];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bpg_lookup.sv
// Table lookup for one registered report: picks the table by kind and
// applies the charger offset for ADC readings. Depends on bpg_pkg.
`default_nettype none

module bpg_lookup (
  input  wire logic [1:0]                 report_kind_i,
  input  wire logic                       charger_present_i,
  input  wire logic [bpg_pkg::LevelW-1:0] level_i,
  input  wire logic [bpg_pkg::LevelW-1:0] charger_offset_i,
  output logic      [bpg_pkg::LevelW-1:0] table_pct_o
);
  import bpg_pkg::*;

  logic [LevelW-1:0] adc_level;

  // The sum wraps at eight bits on purpose.
  assign adc_level = level_i + (charger_present_i ? charger_offset_i : '0);

  always_comb begin
    unique case (report_kind_i)
      KIND_PERCENT: table_pct_o = lin_pick(level_i);
      KIND_ADC:     table_pct_o = adc_pick(adc_level);
      KIND_UNKNOWN,
      KIND_SPARE:   table_pct_o = adc_pick('0);
      default:      table_pct_o = adc_pick('0);
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bpg_filter.sv
// Held-value filter: keeps the held percentage and limits the table result
// to rise while charging and to fall otherwise. Depends on bpg_pkg.
`default_nettype none

module bpg_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bpg_pkg::filt_ctrl_t        ctrl_i,
  input  wire logic [bpg_pkg::LevelW-1:0] table_pct_i,
  output logic      [bpg_pkg::PctW-1:0]   percent_o
);
  import bpg_pkg::*;

  logic [LevelW-1:0] held_q, held_d;
  logic [LevelW-1:0] held_eff;
  logic [LevelW-1:0] res;

  assign held_eff = (ctrl_i.dc && ctrl_i.full) ? FULL_HOLD : held_q;

  always_comb begin
    priority if (held_eff == HELD_NONE) begin
      res = table_pct_i;
    end else if (ctrl_i.dc) begin
      res = (held_eff > table_pct_i) ? held_eff : table_pct_i;
    end else begin
      res = (held_eff > table_pct_i) ? table_pct_i : held_eff;
    end
  end

  // The result never exceeds 100, so the top bit is always clear.
  assign percent_o = ctrl_i.bat ? res[PctW-1:0] : '0;

  always_comb begin
    held_d = held_q;
    if (ctrl_i.update) begin
      held_d = ctrl_i.bat ? res : HELD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= HELD_NONE;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/battery_percent_gauge_top.sv
// Top level of the battery percent gauge: input register, configuration
// register, lookup, filter and result register. Depends on bpg_pkg,
// bpg_lookup and bpg_filter.
//
// Usage:
//   Reports arrive on the in channel (in_valid_i / in_ready_o) and each one
//   yields exactly one percentage on the out channel (out_valid_o /
//   out_ready_i). An item is registered in the input register on acceptance,
//   then looked up and filtered and written to the result register when
//   that register is empty or its item is taken, which raises out_valid_o.
//   Throughput is one item per cycle while out_ready_i stays high: the held
//   percentage is updated in the same cycle as the result register, so each
//   item sees the value left by the one before it without any bubble.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; in_ready_o then drops until the result is taken.
//   The charger offset is written via cfg_we_i / cfg_wdata_i while the block
//   is idle; the user ensures this, not the block. Reset sets the offset to
//   26, clears the held percentage to "none" and empties both registers.
`default_nettype none

module battery_percent_gauge_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bpg_pkg::LevelW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       battery_present_i,
  input  wire logic                       charger_present_i,
  input  wire logic                       charge_full_i,
  input  wire logic [1:0]                 report_kind_i,
  input  wire logic [bpg_pkg::LevelW-1:0] level_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [bpg_pkg::PctW-1:0]   percent_o
);
  import bpg_pkg::*;

  logic [LevelW-1:0] offset_q;

  logic              s1_valid_q;
  logic              s1_bat_q, s1_dc_q, s1_full_q;
  logic [1:0]        s1_kind_q;
  logic [LevelW-1:0] s1_level_q;

  logic              out_valid_q;
  logic [PctW-1:0]   percent_q;

  logic              advance;
  logic              in_fire;
  logic [LevelW-1:0] table_pct;
  logic [PctW-1:0]   percent_d;
  filt_ctrl_t        filt_ctrl;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bat_q   <= battery_present_i;
      s1_dc_q    <= charger_present_i;
      s1_full_q  <= charge_full_i;
      s1_kind_q  <= report_kind_i;
      s1_level_q <= level_i;
    end
  end

  bpg_lookup u_lookup (
    .report_kind_i     (s1_kind_q),
    .charger_present_i (s1_dc_q),
    .level_i           (s1_level_q),
    .charger_offset_i  (offset_q),
    .table_pct_o       (table_pct)
  );

  always_comb begin
    filt_ctrl.update = advance;
    filt_ctrl.bat    = s1_bat_q;
    filt_ctrl.dc     = s1_dc_q;
    filt_ctrl.full   = s1_full_q;
  end

  bpg_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (filt_ctrl),
    .table_pct_i (table_pct),
    .percent_o   (percent_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      percent_q <= percent_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign percent_o   = percent_q;

endmodule

`default_nettype wire
